@@ design/pne_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pne_pkg
// Shared widths, word types, state encodings and helpers for the next edge
// selector.
// ----------------------------------------------------------------------------
package pne_pkg;

    localparam int COORD_W = 12;                       // point coordinate
    localparam int INDEX_W = 10;                       // edge index
    localparam int DELTA_W = COORD_W + 1;              // signed edge vector
    localparam int MAG_W   = 2 * COORD_W + 2;          // |dot product|
    localparam int LEN_W   = 2 * COORD_W + 1;          // squared length
    localparam int SQR_W   = 2 * MAG_W;                // dot product squared
    localparam int ACC_W   = SQR_W + LEN_W + 1;        // signed accumulator
    localparam int OPA_W   = SQR_W;                    // multiplicand
    localparam int OPB_W   = MAG_W;                    // multiplier
    localparam int DIG_W   = 16;                       // multiplier digit
    localparam int NDIG    = (OPB_W + DIG_W - 1) / DIG_W;
    localparam int DCNT_W  = (NDIG > 1) ? $clog2(NDIG) : 1;
    localparam int BEXT_W  = NDIG * DIG_W;
    localparam int PROD_W  = OPA_W + DIG_W;

    typedef logic signed [DELTA_W-1:0] delta_t;

    typedef struct packed {
        logic [COORD_W-1:0] base_start_x;
        logic [COORD_W-1:0] base_start_y;
        logic [COORD_W-1:0] base_end_x;
        logic [COORD_W-1:0] base_end_y;
        logic [COORD_W-1:0] cand_start_x;
        logic [COORD_W-1:0] cand_start_y;
        logic [COORD_W-1:0] cand_end_x;
        logic [COORD_W-1:0] cand_end_y;
        logic [INDEX_W-1:0] cand_index;
        logic               is_last;
    } in_word_t;

    typedef struct packed {
        logic               found;
        logic [INDEX_W-1:0] chosen_index;
        logic               chosen_is_ccw;
    } out_word_t;

    // One candidate as seen by the core, with the current bests.
    typedef struct packed {
        logic   adj;
        delta_t bdx;
        delta_t bdy;
        delta_t cdx;
        delta_t cdy;
        logic   ccw_valid;
        delta_t ccw_dx;
        delta_t ccw_dy;
        logic   cw_valid;
        delta_t cw_dx;
        delta_t cw_dy;
    } job_t;

    typedef struct packed {
        logic             run;
        logic             clear;
        logic             neg;
        logic [OPA_W-1:0] a;
        logic [OPB_W-1:0] b;
    } mac_cmd_t;

    typedef struct packed {
        logic done;
        logic replace;
        logic is_ccw;
    } core_res_t;

    typedef enum logic [1:0] {
        TS_IDLE,
        TS_RUN,
        TS_EMIT
    } top_state_t;

    typedef enum logic [1:0] {
        CS_IDLE,
        CS_MUL,
        CS_NEXT,
        CS_FIN
    } core_state_t;

    // Multiply-accumulate steps of one comparison, in issue order.
    typedef enum logic [3:0] {
        OP_CRS0,
        OP_CRS1,
        OP_DP0,
        OP_DP1,
        OP_DQ0,
        OP_DQ1,
        OP_LP0,
        OP_LP1,
        OP_LQ0,
        OP_LQ1,
        OP_SP,
        OP_SQ,
        OP_CMP0,
        OP_CMP1
    } op_t;

    function automatic op_t op_follow(input op_t op);
        op_t nxt;
        unique case (op)
            OP_CRS0: nxt = OP_CRS1;
            OP_CRS1: nxt = OP_DP0;
            OP_DP0:  nxt = OP_DP1;
            OP_DP1:  nxt = OP_DQ0;
            OP_DQ0:  nxt = OP_DQ1;
            OP_DQ1:  nxt = OP_LP0;
            OP_LP0:  nxt = OP_LP1;
            OP_LP1:  nxt = OP_LQ0;
            OP_LQ0:  nxt = OP_LQ1;
            OP_LQ1:  nxt = OP_SP;
            OP_SP:   nxt = OP_SQ;
            OP_SQ:   nxt = OP_CMP0;
            OP_CMP0: nxt = OP_CMP1;
            OP_CMP1: nxt = OP_CMP1;
            default: nxt = OP_CRS0;
        endcase
        return nxt;
    endfunction

    function automatic logic [DELTA_W-1:0] delta_mag(input delta_t v);
        delta_t n;
        n = -v;
        return v[DELTA_W-1] ? n : v;
    endfunction

endpackage

@@ design/pne_mac.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pne_mac
// Shared multiply-accumulate: acc +/-= a * b, one DIG_W-bit digit of b a
// cycle, stopping at the last nonzero digit.
// ----------------------------------------------------------------------------
module pne_mac
    import pne_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  mac_cmd_t                cmd,
    output logic                    done,
    output logic signed [ACC_W-1:0] acc
);

    localparam int SH_W = $clog2(BEXT_W + 1);

    logic [DCNT_W-1:0]       dcnt_reg;
    logic [DCNT_W-1:0]       dcnt_next;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] acc_next;
    logic signed [ACC_W-1:0] base;
    logic [BEXT_W-1:0]       b_ext;
    logic [BEXT_W-1:0]       rest;
    logic [SH_W-1:0]         shamt;
    logic [DIG_W-1:0]        digit;
    logic [PROD_W-1:0]       prod;
    logic [ACC_W-1:0]        term;

    always_comb begin
        b_ext = BEXT_W'(cmd.b);
        shamt = SH_W'(dcnt_reg) * SH_W'(DIG_W);
        digit = DIG_W'(b_ext >> shamt);
        prod  = PROD_W'(cmd.a) * PROD_W'(digit);
        term  = ACC_W'(prod) << shamt;
        rest  = b_ext >> (shamt + SH_W'(DIG_W));
        done  = cmd.run && (rest == '0);
        base  = (cmd.clear && (dcnt_reg == '0)) ? '0 : acc_reg;

        acc_next  = acc_reg;
        dcnt_next = dcnt_reg;
        if (cmd.run) begin
            acc_next  = cmd.neg ? (base - signed'(term)) : (base + signed'(term));
            dcnt_next = done ? '0 : dcnt_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dcnt_reg <= '0;
        end else begin
            dcnt_reg <= dcnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
    end

    assign acc = acc_reg;

endmodule
`default_nettype wire

@@ design/pne_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pne_core
// Sequencer for one candidate: cross product, dot products, lengths and the
// exact squared-cosine compare, all through the shared MAC.
// ----------------------------------------------------------------------------
module pne_core
    import pne_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      start,
    input  job_t      job,
    output core_res_t res
);

    core_state_t state_reg;
    core_state_t state_next;
    op_t         op_reg;
    op_t         op_next;

    logic             crs_pos_reg, crs_pos_next;
    logic             dp_neg_reg, dp_neg_next;
    logic             dp_zero_reg, dp_zero_next;
    logic [MAG_W-1:0] dp_mag_reg, dp_mag_next;
    logic [MAG_W-1:0] dq_mag_reg, dq_mag_next;
    logic [LEN_W-1:0] lp_reg, lp_next;
    logic [LEN_W-1:0] lq_reg, lq_next;
    logic [SQR_W-1:0] sqp_reg, sqp_next;
    logic [SQR_W-1:0] sqq_reg, sqq_next;
    logic             replace_reg, replace_next;
    logic             ccw_reg, ccw_next;

    mac_cmd_t                cmd;
    logic                    mac_done;
    logic signed [ACC_W-1:0] acc;
    logic                    acc_neg;
    logic                    acc_zero;
    logic [ACC_W-1:0]        acc_mag;

    logic               fin;
    logic               step_replace;
    logic               step_ccw;
    logic               grp_pos;
    logic               p_lt;
    logic               p_gt;
    delta_t             qdx;
    delta_t             qdy;
    logic [DELTA_W-1:0] bx_m, by_m, cx_m, cy_m, qx_m, qy_m;

    pne_mac u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .done    (mac_done),
        .acc     (acc)
    );

    assign acc_neg  = acc[ACC_W-1];
    assign acc_zero = (acc == '0);
    assign acc_mag  = acc_neg ? -acc : acc;

    assign qdx  = crs_pos_reg ? job.ccw_dx : job.cw_dx;
    assign qdy  = crs_pos_reg ? job.ccw_dy : job.cw_dy;
    assign bx_m = delta_mag(job.bdx);
    assign by_m = delta_mag(job.bdy);
    assign cx_m = delta_mag(job.cdx);
    assign cy_m = delta_mag(job.cdy);
    assign qx_m = delta_mag(qdx);
    assign qy_m = delta_mag(qdy);

    // Step decision, evaluated while the finished product sits in the MAC.
    always_comb begin
        fin          = 1'b0;
        step_replace = 1'b0;
        step_ccw     = crs_pos_reg;
        grp_pos      = !acc_neg && !acc_zero;
        p_lt         = 1'b0;
        p_gt         = 1'b0;
        unique case (op_reg)
            OP_CRS1: begin
                step_ccw = grp_pos;
                if (!(grp_pos ? job.ccw_valid : job.cw_valid)) begin
                    fin          = 1'b1;
                    step_replace = 1'b1;
                end
            end
            OP_DQ1: begin
                // sign classes: negative, zero, positive
                p_lt = (dp_neg_reg && !acc_neg) || (dp_zero_reg && grp_pos);
                p_gt = (acc_neg && !dp_neg_reg) || (acc_zero && !dp_neg_reg && !dp_zero_reg);
                if ((dp_neg_reg != acc_neg) || (dp_zero_reg != acc_zero)) begin
                    fin          = 1'b1;
                    step_replace = crs_pos_reg ? p_lt : p_gt;
                end else if (dp_zero_reg) begin
                    fin = 1'b1;
                end
            end
            OP_CMP1: begin
                // acc = dp^2*Lq - dq^2*Lp; flip for a negative dot product
                p_lt         = dp_neg_reg ? grp_pos : acc_neg;
                p_gt         = dp_neg_reg ? acc_neg : grp_pos;
                fin          = 1'b1;
                step_replace = crs_pos_reg ? p_lt : p_gt;
            end
            default: begin
                fin = 1'b0;
            end
        endcase
    end

    // Datapath next values.
    always_comb begin
        op_next      = op_reg;
        crs_pos_next = crs_pos_reg;
        dp_neg_next  = dp_neg_reg;
        dp_zero_next = dp_zero_reg;
        dp_mag_next  = dp_mag_reg;
        dq_mag_next  = dq_mag_reg;
        lp_next      = lp_reg;
        lq_next      = lq_reg;
        sqp_next     = sqp_reg;
        sqq_next     = sqq_reg;
        replace_next = replace_reg;
        ccw_next     = ccw_reg;

        if ((state_reg == CS_IDLE) && start) begin
            op_next      = OP_CRS0;
            replace_next = 1'b0;
            ccw_next     = 1'b0;
        end

        if (state_reg == CS_NEXT) begin
            case (op_reg)
                OP_CRS1: crs_pos_next = grp_pos;
                OP_DP1: begin
                    dp_neg_next  = acc_neg;
                    dp_zero_next = acc_zero;
                    dp_mag_next  = MAG_W'(acc_mag);
                end
                OP_DQ1:  dq_mag_next = MAG_W'(acc_mag);
                OP_LP1:  lp_next     = LEN_W'(acc);
                OP_LQ1:  lq_next     = LEN_W'(acc);
                OP_SP:   sqp_next    = SQR_W'(acc);
                OP_SQ:   sqq_next    = SQR_W'(acc);
                default: sqq_next    = sqq_reg;
            endcase
            if (fin) begin
                replace_next = step_replace;
                ccw_next     = step_ccw;
            end else begin
                op_next = op_follow(op_reg);
            end
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            CS_IDLE: begin
                if (start) begin
                    state_next = job.adj ? CS_MUL : CS_FIN;
                end
            end
            CS_MUL: begin
                if (mac_done) begin
                    state_next = CS_NEXT;
                end
            end
            CS_NEXT: begin
                state_next = fin ? CS_FIN : CS_MUL;
            end
            CS_FIN: begin
                state_next = CS_IDLE;
            end
            default: begin
                state_next = CS_IDLE;
            end
        endcase
    end

    // Outputs: MAC operands per step, decision to the top.
    always_comb begin
        cmd.run   = (state_reg == CS_MUL);
        cmd.clear = 1'b0;
        cmd.neg   = 1'b0;
        cmd.a     = '0;
        cmd.b     = '0;
        unique case (op_reg)
            OP_CRS0: begin
                cmd.clear = 1'b1;
                cmd.a     = OPA_W'(bx_m);
                cmd.b     = OPB_W'(cy_m);
                cmd.neg   = job.bdx[DELTA_W-1] ^ job.cdy[DELTA_W-1];
            end
            OP_CRS1: begin
                cmd.a   = OPA_W'(by_m);
                cmd.b   = OPB_W'(cx_m);
                cmd.neg = ~(job.bdy[DELTA_W-1] ^ job.cdx[DELTA_W-1]);
            end
            OP_DP0: begin
                cmd.clear = 1'b1;
                cmd.a     = OPA_W'(bx_m);
                cmd.b     = OPB_W'(cx_m);
                cmd.neg   = job.bdx[DELTA_W-1] ^ job.cdx[DELTA_W-1];
            end
            OP_DP1: begin
                cmd.a   = OPA_W'(by_m);
                cmd.b   = OPB_W'(cy_m);
                cmd.neg = job.bdy[DELTA_W-1] ^ job.cdy[DELTA_W-1];
            end
            OP_DQ0: begin
                cmd.clear = 1'b1;
                cmd.a     = OPA_W'(bx_m);
                cmd.b     = OPB_W'(qx_m);
                cmd.neg   = job.bdx[DELTA_W-1] ^ qdx[DELTA_W-1];
            end
            OP_DQ1: begin
                cmd.a   = OPA_W'(by_m);
                cmd.b   = OPB_W'(qy_m);
                cmd.neg = job.bdy[DELTA_W-1] ^ qdy[DELTA_W-1];
            end
            OP_LP0: begin
                cmd.clear = 1'b1;
                cmd.a     = OPA_W'(cx_m);
                cmd.b     = OPB_W'(cx_m);
            end
            OP_LP1: begin
                cmd.a = OPA_W'(cy_m);
                cmd.b = OPB_W'(cy_m);
            end
            OP_LQ0: begin
                cmd.clear = 1'b1;
                cmd.a     = OPA_W'(qx_m);
                cmd.b     = OPB_W'(qx_m);
            end
            OP_LQ1: begin
                cmd.a = OPA_W'(qy_m);
                cmd.b = OPB_W'(qy_m);
            end
            OP_SP: begin
                cmd.clear = 1'b1;
                cmd.a     = OPA_W'(dp_mag_reg);
                cmd.b     = dp_mag_reg;
            end
            OP_SQ: begin
                cmd.clear = 1'b1;
                cmd.a     = OPA_W'(dq_mag_reg);
                cmd.b     = dq_mag_reg;
            end
            OP_CMP0: begin
                cmd.clear = 1'b1;
                cmd.a     = sqp_reg;
                cmd.b     = OPB_W'(lq_reg);
            end
            OP_CMP1: begin
                cmd.a   = sqq_reg;
                cmd.b   = OPB_W'(lp_reg);
                cmd.neg = 1'b1;
            end
            default: begin
                cmd.a = '0;
            end
        endcase

        res.done    = (state_reg == CS_FIN);
        res.replace = replace_reg;
        res.is_ccw  = ccw_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= CS_IDLE;
            op_reg      <= OP_CRS0;
            replace_reg <= 1'b0;
            ccw_reg     <= 1'b0;
        end else begin
            state_reg   <= state_next;
            op_reg      <= op_next;
            replace_reg <= replace_next;
            ccw_reg     <= ccw_next;
        end
    end

    always_ff @(posedge aclk) begin
        crs_pos_reg <= crs_pos_next;
        dp_neg_reg  <= dp_neg_next;
        dp_zero_reg <= dp_zero_next;
        dp_mag_reg  <= dp_mag_next;
        dq_mag_reg  <= dq_mag_next;
        lp_reg      <= lp_next;
        lq_reg      <= lq_next;
        sqp_reg     <= sqp_next;
        sqq_reg     <= sqq_next;
    end

endmodule
`default_nettype wire

@@ design/planar_next_edge_select.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// planar_next_edge_select
// Picks the next edge of a planar face walk from a stream of candidate
// edges, keeping the widest counterclockwise and narrowest clockwise turn.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake          | word
//  --------+-----+--------------------+--------------------------------------
//  s_      | in  | s_valid / s_ready  | in_word_t: base edge, candidate, index
//  m_      | out | m_valid / m_ready  | out_word_t: found, index, ccw flag
//
//  One candidate word at a time. At 12-bit coordinates a non-adjacent word skips
//  the MAC; otherwise the cross product ends it when its turn group is still
//  empty, the dot products when their signs settle the compare, and else the
//  full squared-cosine test follows (the squares and the cross products of
//  magnitudes take one or two digits); every step is one pass per 16-bit digit
//  through the shared MAC and a sequencing state. A last word posts the result.
//  Reset (aresetn low, synchronous) empties both groups and the output slot.
//  A result waiting on m_ready does not stop new candidates; only a second
//  last word waits until the slot frees.
// ----------------------------------------------------------------------------
module planar_next_edge_select
    import pne_pkg::*;
(
    input  wire        aclk,
    input  wire        aresetn,
    input  wire        s_valid,
    output logic       s_ready,
    input  in_word_t   s_data,
    output logic       m_valid,
    input  wire        m_ready,
    output out_word_t  m_data
);

    top_state_t state_reg;
    top_state_t state_next;

    logic accept;
    logic out_free;
    logic emit;
    logic start_reg;
    logic start_next;

    // captured candidate
    delta_t             bdx_reg, bdy_reg, cdx_reg, cdy_reg;
    delta_t             bdx_in, bdy_in, cdx_in, cdy_in;
    logic               adj_reg, adj_in;
    logic [INDEX_W-1:0] idx_reg;
    logic               last_reg;

    // running bests of each turn group
    logic               ccw_valid_reg, ccw_valid_next;
    logic [INDEX_W-1:0] ccw_idx_reg, ccw_idx_next;
    delta_t             ccw_dx_reg, ccw_dx_next;
    delta_t             ccw_dy_reg, ccw_dy_next;
    logic               cw_valid_reg, cw_valid_next;
    logic [INDEX_W-1:0] cw_idx_reg, cw_idx_next;
    delta_t             cw_dx_reg, cw_dx_next;
    delta_t             cw_dy_reg, cw_dy_next;

    logic      m_valid_reg, m_valid_next;
    out_word_t m_data_reg, m_data_next;

    job_t      job;
    core_res_t core_res;

    logic joins, same, rev, nonzero;

    // Edge vectors and adjacency of the incoming word.
    always_comb begin
        bdx_in  = DELTA_W'({1'b0, s_data.base_end_x}) - DELTA_W'({1'b0, s_data.base_start_x});
        bdy_in  = DELTA_W'({1'b0, s_data.base_end_y}) - DELTA_W'({1'b0, s_data.base_start_y});
        cdx_in  = DELTA_W'({1'b0, s_data.cand_end_x}) - DELTA_W'({1'b0, s_data.cand_start_x});
        cdy_in  = DELTA_W'({1'b0, s_data.cand_end_y}) - DELTA_W'({1'b0, s_data.cand_start_y});
        joins   = (s_data.cand_start_x == s_data.base_end_x)
               && (s_data.cand_start_y == s_data.base_end_y);
        same    = (s_data.cand_start_x == s_data.base_start_x)
               && (s_data.cand_start_y == s_data.base_start_y)
               && (s_data.cand_end_x == s_data.base_end_x)
               && (s_data.cand_end_y == s_data.base_end_y);
        rev     = joins
               && (s_data.cand_end_x == s_data.base_start_x)
               && (s_data.cand_end_y == s_data.base_start_y);
        nonzero = (s_data.cand_end_x != s_data.cand_start_x)
               || (s_data.cand_end_y != s_data.cand_start_y);
        adj_in  = joins && !same && !rev && nonzero;
    end

    always_comb begin
        job.adj       = adj_reg;
        job.bdx       = bdx_reg;
        job.bdy       = bdy_reg;
        job.cdx       = cdx_reg;
        job.cdy       = cdy_reg;
        job.ccw_valid = ccw_valid_reg;
        job.ccw_dx    = ccw_dx_reg;
        job.ccw_dy    = ccw_dy_reg;
        job.cw_valid  = cw_valid_reg;
        job.cw_dx     = cw_dx_reg;
        job.cw_dy     = cw_dy_reg;
    end

    pne_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (start_reg),
        .job     (job),
        .res     (core_res)
    );

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            TS_IDLE: begin
                if (accept) begin
                    state_next = TS_RUN;
                end
            end
            TS_RUN: begin
                if (core_res.done) begin
                    state_next = last_reg ? TS_EMIT : TS_IDLE;
                end
            end
            TS_EMIT: begin
                if (out_free) begin
                    state_next = TS_IDLE;
                end
            end
            default: begin
                state_next = TS_IDLE;
            end
        endcase
    end

    // Handshake outputs.
    always_comb begin
        s_ready    = (state_reg == TS_IDLE);
        accept     = s_valid && s_ready;
        out_free   = !m_valid_reg || m_ready;
        emit       = (state_reg == TS_EMIT) && out_free;
        start_next = accept;
    end

    // Best tracking, result slot.
    always_comb begin
        ccw_valid_next = ccw_valid_reg;
        ccw_idx_next   = ccw_idx_reg;
        ccw_dx_next    = ccw_dx_reg;
        ccw_dy_next    = ccw_dy_reg;
        cw_valid_next  = cw_valid_reg;
        cw_idx_next    = cw_idx_reg;
        cw_dx_next     = cw_dx_reg;
        cw_dy_next     = cw_dy_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_data_next    = m_data_reg;

        if (core_res.done && core_res.replace) begin
            if (core_res.is_ccw) begin
                ccw_valid_next = 1'b1;
                ccw_idx_next   = idx_reg;
                ccw_dx_next    = cdx_reg;
                ccw_dy_next    = cdy_reg;
            end else begin
                cw_valid_next = 1'b1;
                cw_idx_next   = idx_reg;
                cw_dx_next    = cdx_reg;
                cw_dy_next    = cdy_reg;
            end
        end

        if (emit) begin
            m_valid_next              = 1'b1;
            m_data_next.found         = ccw_valid_reg || cw_valid_reg;
            m_data_next.chosen_is_ccw = ccw_valid_reg;
            if (ccw_valid_reg) begin
                m_data_next.chosen_index = ccw_idx_reg;
            end else if (cw_valid_reg) begin
                m_data_next.chosen_index = cw_idx_reg;
            end else begin
                m_data_next.chosen_index = '0;
            end
            ccw_valid_next = 1'b0;
            cw_valid_next  = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= TS_IDLE;
            start_reg     <= 1'b0;
            ccw_valid_reg <= 1'b0;
            cw_valid_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            start_reg     <= start_next;
            ccw_valid_reg <= ccw_valid_next;
            cw_valid_reg  <= cw_valid_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            bdx_reg  <= bdx_in;
            bdy_reg  <= bdy_in;
            cdx_reg  <= cdx_in;
            cdy_reg  <= cdy_in;
            adj_reg  <= adj_in;
            idx_reg  <= s_data.cand_index;
            last_reg <= s_data.is_last;
        end
        ccw_idx_reg <= ccw_idx_next;
        ccw_dx_reg  <= ccw_dx_next;
        ccw_dy_reg  <= ccw_dy_next;
        cw_idx_reg  <= cw_idx_next;
        cw_dx_reg   <= cw_dx_next;
        cw_dy_reg   <= cw_dy_next;
        m_data_reg  <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // core finishes only for a word we are waiting on
    a_done_in_run: assert property (@(posedge aclk) disable iff (!aresetn)
        core_res.done |-> (state_reg == TS_RUN))
        else $error("core done outside of run");

    // a non-adjacent candidate never becomes a best
    a_no_adj_no_replace: assert property (@(posedge aclk) disable iff (!aresetn)
        (core_res.done && !adj_reg) |-> !core_res.replace)
        else $error("non-adjacent candidate taken");

    // posting a result empties both groups for the next query
    a_emit_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |=> (!ccw_valid_reg && !cw_valid_reg))
        else $error("groups not cleared after result");

    // not found reports index 0, clockwise flag
    a_not_found_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.found) |-> ((m_data.chosen_index == '0) && !m_data.chosen_is_ccw))
        else $error("not-found result carries data");

endmodule
`default_nettype wire
